/* src/rtc_pkg.sv */
// shared types, codes and helper functions for the serial real-time clock
// no dependencies
`default_nettype none

package rtc_pkg;

  // classified pin request handed from the front to the back
  typedef struct packed {
    logic        is_read;
    logic [15:0] elapsed;
    logic        run_cmd;
    logic        shift_clk;
    logic        data_pin;
  } item_t;

  // request and response of the shared remainder unit
  typedef struct packed {
    logic        start;
    logic [31:0] num;
    logic [31:0] den;
  } mod_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [31:0] rem;
  } mod_rsp_t;

  localparam logic [23:0] CPS_RESET = 24'd12000000;
  localparam logic [31:0] PI_RESET  = 32'd187500;

  // serial commands
  localparam logic [3:0] CMD_HOLD     = 4'd0;
  localparam logic [3:0] CMD_SHIFT    = 4'd1;
  localparam logic [3:0] CMD_SET      = 4'd2;
  localparam logic [3:0] CMD_READ     = 4'd3;
  localparam logic [3:0] CMD_F64      = 4'd4;
  localparam logic [3:0] CMD_F256     = 4'd5;
  localparam logic [3:0] CMD_F2048    = 4'd6;
  localparam logic [3:0] CMD_F4096    = 4'd7;
  localparam logic [3:0] CMD_I1       = 4'd8;
  localparam logic [3:0] CMD_I10      = 4'd9;
  localparam logic [3:0] CMD_I30      = 4'd10;
  localparam logic [3:0] CMD_I60      = 4'd11;
  localparam logic [3:0] CMD_IRESET   = 4'd12;
  localparam logic [3:0] CMD_START    = 4'd13;
  localparam logic [3:0] CMD_STOP     = 4'd14;

  // shift register modes
  localparam logic [1:0] SM_HOLD  = 2'd0;
  localparam logic [1:0] SM_SHIFT = 2'd1;
  localparam logic [1:0] SM_SET   = 2'd2;

  // timing pulse modes
  localparam logic [1:0] PM_RUN     = 2'd0;
  localparam logic [1:0] PM_ONESHOT = 2'd1;
  localparam logic [1:0] PM_STOP    = 2'd2;

  // two bcd digits of a value below 100, tens by reciprocal multiply
  function automatic logic [7:0] to_bcd(input logic [6:0] v);
    logic [14:0] p;
    logic [3:0]  t;
    logic [6:0]  o;
    p = {8'd0, v} * 15'd205;
    t = p[14:11];
    o = v - {3'd0, t} * 7'd10;
    return {t, o[3:0]};
  endfunction

  // low digit plus ten times high digit
  function automatic logic [7:0] from_bcd(input logic [7:0] b);
    return 8'(b[3:0]) + 8'(b[7:4]) * 8'd10;
  endfunction

  // month length, anything outside one to twelve counts 31
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic [6:0] y);
    logic [4:0] d;
    case (m)
      4'd2:                   d = (y[1:0] == 2'd0) ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
      default:                d = 5'd31;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

/* src/rtc_if.sv */
// valid/ready channels of the serial real-time clock
// no dependencies
`default_nettype none

interface rtc_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [15:0] elapsed;
  logic        clk_pin;
  logic        stb_pin;
  logic        data_pin;
  modport source(output valid, func, elapsed, clk_pin, stb_pin, data_pin, input ready);
  modport sink(input valid, func, elapsed, clk_pin, stb_pin, data_pin, output ready);
endinterface

interface rtc_out_if;
  logic valid;
  logic ready;
  logic data_out;
  logic tp_out;
  modport source(output valid, data_out, tp_out, input ready);
  modport sink(input valid, data_out, tp_out, output ready);
endinterface

`default_nettype wire

/* src/rtc_front.sv */
// front: accepts pin requests, finds strobe and clock edges, two-entry queue
// depends on rtc_pkg, rtc_if
`default_nettype none

module rtc_front (
  input  wire logic          clk,
  input  wire logic          rst,
  rtc_in_if.sink             item,
  output rtc_pkg::item_t     q_item,
  output logic               q_valid,
  input  wire logic          q_pop
);

  rtc_pkg::item_t mem [2];
  logic           wptr;
  logic           rptr;
  logic [1:0]     count;
  logic           last_clk;
  logic           last_stb;
  logic           push;
  rtc_pkg::item_t cls;

  assign item.ready = (count != 2'd2);
  assign push       = item.valid && item.ready;
  assign q_valid    = (count != 2'd0);
  assign q_item     = mem[rptr];

  // classify against the pin levels of the previous write
  always_comb begin
    cls.is_read   = item.func;
    cls.elapsed   = item.elapsed;
    cls.run_cmd   = !item.func && item.stb_pin && !last_stb;
    cls.shift_clk = !item.func && !item.stb_pin && item.clk_pin && !last_clk;
    cls.data_pin  = item.data_pin;
  end

  // pin history
  always_ff @(posedge clk) begin
    if (rst) begin
      last_clk <= 1'b0;
      last_stb <= 1'b0;
    end else if (push && !item.func) begin
      last_clk <= item.clk_pin;
      last_stb <= item.stb_pin;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= cls;
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= !wptr;
      if (q_pop) rptr <= !rptr;
      count <= count + 2'(push) - 2'(q_pop);
    end
  end

endmodule

`default_nettype wire

/* src/rtc_mod.sv */
// shared remainder unit, restoring, one quotient bit per cycle
// depends on rtc_pkg
`default_nettype none

module rtc_mod (
  input  wire logic        clk,
  input  wire logic        rst,
  input  rtc_pkg::mod_req_t req,
  output rtc_pkg::mod_rsp_t rsp
);

  logic        busy;
  logic        done;
  logic [4:0]  cnt;
  logic [31:0] num;
  logic [31:0] den;
  logic [31:0] rem;
  logic [32:0] trial;
  logic [32:0] diff;

  assign trial = {rem, num[31]};
  assign diff  = trial - {1'b0, den};

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.rem  = (den == 32'd0) ? 32'd0 : rem;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 5'd0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy <= 1'b1;
        cnt  <= 5'd0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start && !busy) begin
      num <= req.num;
      den <= req.den;
      rem <= 32'd0;
    end else if (busy) begin
      num <= {num[30:0], 1'b0};
      rem <= diff[32] ? trial[31:0] : diff[31:0];
    end
  end

endmodule

`default_nettype wire

/* src/rtc_back.sv */
// back: prescalers, calendar, command execution and result register
// depends on rtc_pkg, rtc_if; uses the shared remainder unit through ports
`default_nettype none

module rtc_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_we,
  input  wire logic [23:0]   cfg_wdata,
  input  rtc_pkg::item_t     q_item,
  input  wire logic          q_valid,
  output logic               q_pop,
  output rtc_pkg::mod_req_t  mod_req,
  input  rtc_pkg::mod_rsp_t  mod_rsp,
  rtc_out_if.source          result
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_PULSE = 7'b0000010,
    S_PWAIT = 7'b0000100,
    S_SEC   = 7'b0001000,
    S_SWAIT = 7'b0010000,
    S_ACT   = 7'b0100000,
    S_CWAIT = 7'b1000000
  } state_t;

  state_t         state;
  rtc_pkg::item_t cur;
  logic [23:0]    cps;
  logic [5:0]     sec;
  logic [5:0]     minute;
  logic [4:0]     hour;
  logic [4:0]     day_of_month;
  logic [3:0]     month_num;
  logic [6:0]     year_num;
  logic [2:0]     week_day;
  logic [1:0]     shift_mode;
  logic [1:0]     pulse_mode;
  logic [47:0]    shift_reg;
  logic [3:0]     cmd_reg;
  logic [31:0]    sec_count;
  logic [31:0]    pulse_count;
  logic [31:0]    pulse_interval;
  logic           pulse_level;
  logic           ovalid;
  logic           odata;
  logic           otp;

  logic [31:0] pc_sum;
  logic [31:0] sc_sum;
  logic [31:0] cps32;
  logic [31:0] new_pi;
  logic        out_free;

  // calendar one second later
  logic [5:0] sec_next;
  logic [5:0] minute_next;
  logic [4:0] hour_next;
  logic [4:0] day_next;
  logic [3:0] month_next;
  logic [6:0] year_next;
  logic [2:0] wday_next;

  assign cps32    = {8'd0, cps};
  assign pc_sum   = pulse_count + {16'd0, cur.elapsed};
  assign sc_sum   = sec_count + {16'd0, cur.elapsed};
  assign out_free = !ovalid || result.ready;
  assign q_pop    = (state == S_IDLE) && q_valid;

  assign result.valid    = ovalid;
  assign result.data_out = odata;
  assign result.tp_out   = otp;

  // compare before incrementing so out-of-range fields still roll over
  always_comb begin
    logic [5:0] dd;
    logic [4:0] dim;
    logic [3:0] m4;
    logic [6:0] y7;
    sec_next    = sec;
    minute_next = minute;
    hour_next   = hour;
    day_next    = day_of_month;
    month_next  = month_num;
    year_next   = year_num;
    wday_next   = week_day;
    dim = rtc_pkg::month_len(month_num, year_num);
    dd  = {1'b0, day_of_month} + 6'd1;
    m4  = month_num + 4'd1;
    y7  = year_num + 7'd1;
    if (sec < 6'd59) begin
      sec_next = sec + 6'd1;
    end else begin
      sec_next = 6'd0;
      if (minute < 6'd59) begin
        minute_next = minute + 6'd1;
      end else begin
        minute_next = 6'd0;
        if (hour < 5'd23) begin
          hour_next = hour + 5'd1;
        end else begin
          hour_next = 5'd0;
          wday_next = (week_day >= 3'd6) ? 3'd0 : week_day + 3'd1;
          if (dd > {1'b0, dim}) begin
            day_next = 5'd1;
            if (month_num >= 4'd12) begin
              month_next = 4'd1;
              year_next  = (year_num >= 7'd99) ? 7'd0 : y7;
            end else begin
              month_next = m4;
            end
          end else begin
            day_next = dd[4:0];
          end
        end
      end
    end
  end

  // pulse interval chosen by the pending command
  always_comb begin
    case (cmd_reg)
      rtc_pkg::CMD_F256:  new_pi = cps32 >> 8;
      rtc_pkg::CMD_F2048: new_pi = cps32 >> 11;
      rtc_pkg::CMD_F4096: new_pi = cps32 >> 12;
      default:            new_pi = cps32 >> 6;
    endcase
  end

  // remainder requests
  always_comb begin
    mod_req.start = 1'b0;
    mod_req.num   = pc_sum;
    mod_req.den   = pulse_interval;
    case (state)
      S_PULSE: mod_req.start = (pulse_mode != rtc_pkg::PM_STOP) && (pc_sum >= pulse_interval);
      S_SEC: begin
        mod_req.start = (sc_sum >= cps32);
        mod_req.num   = sc_sum;
        mod_req.den   = cps32;
      end
      S_ACT: begin
        mod_req.start = !cur.is_read && cur.run_cmd &&
                        (cmd_reg == rtc_pkg::CMD_HOLD || cmd_reg == rtc_pkg::CMD_F64 ||
                         cmd_reg == rtc_pkg::CMD_F256 || cmd_reg == rtc_pkg::CMD_F2048 ||
                         cmd_reg == rtc_pkg::CMD_F4096);
        mod_req.num   = pulse_count;
        mod_req.den   = new_pi;
      end
      default: mod_req.start = 1'b0;
    endcase
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) cps <= rtc_pkg::CPS_RESET;
    else if (cfg_we) cps <= cfg_wdata;
  end

  // sequencer and clock state
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      sec            <= 6'd0;
      minute         <= 6'd0;
      hour           <= 5'd0;
      day_of_month   <= 5'd1;
      month_num      <= 4'd1;
      year_num       <= 7'd0;
      week_day       <= 3'd0;
      shift_mode     <= rtc_pkg::SM_HOLD;
      pulse_mode     <= rtc_pkg::PM_RUN;
      shift_reg      <= 48'd0;
      cmd_reg        <= 4'd0;
      sec_count      <= 32'd0;
      pulse_count    <= 32'd0;
      pulse_interval <= rtc_pkg::PI_RESET;
      pulse_level    <= 1'b0;
      ovalid         <= 1'b0;
    end else begin
      if (ovalid && result.ready && !(state == S_ACT && cur.is_read)) ovalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur   <= q_item;
            state <= S_PULSE;
          end
        end
        // timing pulse counter
        S_PULSE: begin
          state <= mod_req.start ? S_PWAIT : S_SEC;
          if (pulse_mode != rtc_pkg::PM_STOP) begin
            pulse_count <= pc_sum;
            if (pc_sum < pulse_interval && pulse_mode != rtc_pkg::PM_ONESHOT)
              pulse_level <= (pc_sum >= (pulse_interval >> 1));
          end
        end
        S_PWAIT: begin
          if (mod_rsp.done) begin
            pulse_count <= mod_rsp.rem;
            pulse_level <= (mod_rsp.rem >= (pulse_interval >> 1));
            if (pulse_mode == rtc_pkg::PM_ONESHOT) pulse_mode <= rtc_pkg::PM_RUN;
            state <= S_SEC;
          end
        end
        // seconds prescaler
        S_SEC: begin
          sec_count <= sc_sum;
          state     <= (sc_sum >= cps32) ? S_SWAIT : S_ACT;
        end
        S_SWAIT: begin
          if (mod_rsp.done) begin
            sec_count    <= mod_rsp.rem;
            sec          <= sec_next;
            minute       <= minute_next;
            hour         <= hour_next;
            day_of_month <= day_next;
            month_num    <= month_next;
            year_num     <= year_next;
            week_day     <= wday_next;
            state        <= S_ACT;
          end
        end
        // read result, command or serial shift
        S_ACT: begin
          if (cur.is_read) begin
            if (out_free) begin
              ovalid <= 1'b1;
              odata  <= (shift_mode == rtc_pkg::SM_HOLD) ? (sec_count >= (cps32 >> 1))
                                                         : shift_reg[0];
              otp    <= pulse_level;
              state  <= S_IDLE;
            end
          end else if (cur.run_cmd) begin
            // hold and frequency commands wait for the counter reduction
            state <= mod_req.start ? S_CWAIT : S_IDLE;
            case (cmd_reg)
              rtc_pkg::CMD_HOLD: begin
                shift_mode     <= rtc_pkg::SM_HOLD;
                pulse_mode     <= rtc_pkg::PM_RUN;
                pulse_interval <= new_pi;
              end
              rtc_pkg::CMD_SHIFT: shift_mode <= rtc_pkg::SM_SHIFT;
              rtc_pkg::CMD_SET: begin
                shift_mode   <= rtc_pkg::SM_SET;
                sec          <= 6'(rtc_pkg::from_bcd(shift_reg[7:0]));
                minute       <= 6'(rtc_pkg::from_bcd(shift_reg[15:8]));
                hour         <= 5'(rtc_pkg::from_bcd(shift_reg[23:16]));
                day_of_month <= 5'(rtc_pkg::from_bcd(shift_reg[31:24]));
                week_day     <= shift_reg[34:32];
                month_num    <= shift_reg[39:36];
                year_num     <= 7'(rtc_pkg::from_bcd(shift_reg[47:40]));
              end
              rtc_pkg::CMD_READ: begin
                shift_mode <= rtc_pkg::SM_HOLD;
                shift_reg  <= {rtc_pkg::to_bcd(year_num), month_num, 1'b0, week_day,
                               rtc_pkg::to_bcd({2'd0, day_of_month}),
                               rtc_pkg::to_bcd({2'd0, hour}),
                               rtc_pkg::to_bcd({1'b0, minute}),
                               rtc_pkg::to_bcd({1'b0, sec})};
              end
              rtc_pkg::CMD_F64, rtc_pkg::CMD_F256, rtc_pkg::CMD_F2048,
              rtc_pkg::CMD_F4096: begin
                pulse_mode     <= rtc_pkg::PM_RUN;
                pulse_interval <= new_pi;
              end
              rtc_pkg::CMD_I1: begin
                pulse_mode <= rtc_pkg::PM_RUN;
                pulse_interval <= cps32;
                pulse_count <= 32'd0;
              end
              rtc_pkg::CMD_I10: begin
                pulse_mode <= rtc_pkg::PM_RUN;
                pulse_interval <= (cps32 << 3) + (cps32 << 1);
                pulse_count <= 32'd0;
              end
              rtc_pkg::CMD_I30: begin
                pulse_mode <= rtc_pkg::PM_RUN;
                pulse_interval <= (cps32 << 5) - (cps32 << 1);
                pulse_count <= 32'd0;
              end
              rtc_pkg::CMD_I60: begin
                pulse_mode <= rtc_pkg::PM_RUN;
                pulse_interval <= (cps32 << 6) - (cps32 << 2);
                pulse_count <= 32'd0;
              end
              rtc_pkg::CMD_IRESET: begin
                pulse_mode  <= rtc_pkg::PM_ONESHOT;
                pulse_level <= 1'b1;
              end
              rtc_pkg::CMD_START: pulse_mode <= rtc_pkg::PM_RUN;
              rtc_pkg::CMD_STOP:  pulse_mode <= rtc_pkg::PM_STOP;
              default: ;
            endcase
          end else begin
            state <= S_IDLE;
            if (cur.shift_clk) begin
              if (shift_mode == rtc_pkg::SM_SHIFT)
                shift_reg <= {cmd_reg[0], shift_reg[47:1]};
              cmd_reg <= {cur.data_pin, cmd_reg[3:1]};
            end
          end
        end
        // pulse counter reduced to the new interval
        S_CWAIT: begin
          if (mod_rsp.done) begin
            pulse_count <= mod_rsp.rem;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

/* src/serial_rtc_with_timing_pulse.sv */
// top level of the serial real-time clock with timing pulse
// depends on rtc_pkg, rtc_if, rtc_front, rtc_mod, rtc_back
//
// channel  dir  handshake    payload
// item     in   valid/ready  func, elapsed, clk_pin, stb_pin, data_pin
// result   out  valid/ready  data_out, tp_out (one per read request)
// cfg      in   cfg_we       cfg_wdata = cycles_per_second
//
// a request passes through the idle, pulse, seconds and action states in the
// back, plus a wait state for each wrap that needs a remainder (pulse counter,
// seconds prescaler, hold or frequency command) from the shared bit-serial remainder unit.
// a two-entry queue lets the front take requests while the back works.
// rst is synchronous and clears all clock and pulse state; a stalled result
// holds the back only on the next read request.
`default_nettype none

module serial_rtc_with_timing_pulse (
  input  wire logic        clk,
  input  wire logic        rst,
  rtc_in_if.sink           item,
  rtc_out_if.source        result,
  input  wire logic        cfg_we,
  input  wire logic [23:0] cfg_wdata
);

  rtc_pkg::item_t    q_item;
  logic              q_valid;
  logic              q_pop;
  rtc_pkg::mod_req_t mod_req;
  rtc_pkg::mod_rsp_t mod_rsp;

  rtc_front u_front (
    .clk     (clk),
    .rst     (rst),
    .item    (item),
    .q_item  (q_item),
    .q_valid (q_valid),
    .q_pop   (q_pop)
  );

  rtc_mod u_mod (
    .clk (clk),
    .rst (rst),
    .req (mod_req),
    .rsp (mod_rsp)
  );

  rtc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_item    (q_item),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .mod_req   (mod_req),
    .mod_rsp   (mod_rsp),
    .result    (result)
  );

  // back pops only what the queue holds
  a_pop_valid: assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("queue popped while empty");

  // remainder unit is never restarted while busy
  a_mod_free: assert property (@(posedge clk) disable iff (rst)
    mod_req.start |-> !mod_rsp.busy)
    else $error("remainder request while busy");

  // completion follows a busy cycle
  a_mod_done: assert property (@(posedge clk) disable iff (rst)
    mod_rsp.done |-> $past(mod_rsp.busy))
    else $error("remainder done without work");

  // no new request is taken while the remainder unit runs
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    mod_rsp.busy |-> !q_pop)
    else $error("pop during remainder");

endmodule

`default_nettype wire
